// ----- design/rlrm_pkg.sv -----
`timescale 1ns / 1ps

package rlrm_pkg;

  // Field widths fixed by the port definition.
  localparam int LEN_BITS = 31;
  localparam int RUN_BITS = LEN_BITS + 1;
  localparam int DEFAULT_MAX_RUNS = 256;

  typedef logic [LEN_BITS-1:0] len_t;
  typedef logic [LEN_BITS:0]   sum_t;

  // One run: resident flag on top, byte count below.
  typedef struct packed {
    logic flag;
    len_t len;
  } run_t;

  typedef enum logic [1:0] {
    CMD_CUT,
    CMD_GROW,
    CMD_QUERY,
    CMD_MARK
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK,
    STAT_ZERO,
    STAT_PAST,
    STAT_INCONS,
    STAT_FULL
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CALC1,
    S_CALC2,
    S_CALC3,
    S_COPY,
    S_DONE
  } state_t;

endpackage

// ----- design/rlrm_ram.sv -----
`timescale 1ns / 1ps

module rlrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/rlrm_ctrl.sv -----
`timescale 1ns / 1ps

module rlrm_ctrl #(
  parameter int MAX_RUNS = rlrm_pkg::DEFAULT_MAX_RUNS
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  output logic                                         busy,
  input  logic [1:0]                                   command,
  input  rlrm_pkg::len_t                               position,
  input  rlrm_pkg::len_t                               end_pos,
  input  rlrm_pkg::len_t                               length,
  output logic                                         done,
  output logic                                         in_terminal,
  output rlrm_pkg::len_t                               range_start,
  output rlrm_pkg::len_t                               range_end,
  output rlrm_pkg::status_t                            status,
  output logic [((MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1)-1:0] mem_raddr,
  input  rlrm_pkg::run_t                               mem_rdata,
  output logic                                         mem_we,
  output logic [((MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1)-1:0] mem_waddr,
  output rlrm_pkg::run_t                               mem_wdata,
  output logic                                         bank
);

  localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int IW = $clog2(MAX_RUNS + 1);
  localparam int XW = IW + 1;
  localparam int LB = rlrm_pkg::LEN_BITS;

  typedef logic [IW-1:0] idx_t;
  typedef logic [XW-1:0] idx_x_t;

  rlrm_pkg::state_t state, state_next;

  // Latched request.
  rlrm_pkg::cmd_t cmd;
  rlrm_pkg::len_t pos, endp, len;

  idx_t count;

  // Scan pass.
  idx_t           rd_cnt;
  logic           d_valid;
  idx_t           d_idx;
  rlrm_pkg::sum_t sum;
  rlrm_pkg::run_t last;
  logic           a_found, b_found;
  idx_t           a_idx, b_idx;
  rlrm_pkg::sum_t a_start, a_end, b_end;
  rlrm_pkg::run_t a_prev, a_cur, a_n1, a_n2, b_cur, b_n1;

  // First compute stage.
  rlrm_pkg::len_t a_off, a_rest, b_tail;
  rlrm_pkg::sum_t tot_n;

  // Mark preparation stage.
  logic           mk_early, mk_incons, mk_prev_ex, mk_next_ex;
  idx_t           mk_idx;
  rlrm_pkg::len_t mk_cur, mk_off, mk_rest, mk_n;
  rlrm_pkg::run_t mk_prev, mk_next;

  // Result.
  logic              res_term;
  rlrm_pkg::len_t    res_rs, res_re;
  rlrm_pkg::status_t res_status;

  // Edit: old runs [ed_a, ed_b) are replaced by ed_k new runs.
  idx_t           ed_a, ed_b, new_count;
  logic [1:0]     ed_k;
  rlrm_pkg::run_t ed_e0, ed_e1, ed_e2;

  // Copy pass.
  idx_t       cp_o;
  logic       w_valid, w_ram;
  idx_t       w_idx;
  logic [1:0] w_ent;

  // Index helpers.
  idx_x_t count_x, a_idx_x, b_idx_x;
  logic   a_has_prev, a_has_cur, a_has_n1, a_has_n2, b_has_n1;

  assign count_x    = {1'b0, count};
  assign a_idx_x    = {1'b0, a_idx};
  assign b_idx_x    = {1'b0, b_idx};
  assign a_has_prev = (a_idx != '0);
  assign a_has_cur  = (a_idx < count);
  assign a_has_n1   = ((a_idx_x + XW'(1)) < count_x);
  assign a_has_n2   = ((a_idx_x + XW'(2)) < count_x);
  assign b_has_n1   = ((b_idx_x + XW'(1)) < count_x);

  // Scan step on the entry that arrives from memory.
  rlrm_pkg::sum_t d_sum;
  rlrm_pkg::len_t b_target;
  logic           a_hit, b_hit, scan_end;

  assign d_sum    = sum + {1'b0, mem_rdata.len};
  assign b_target = endp - LB'(1);
  assign a_hit    = !a_found && (d_sum > {1'b0, pos});
  assign b_hit    = !b_found && (d_sum > {1'b0, b_target});
  assign scan_end = (state == rlrm_pkg::S_SCAN) && (rd_cnt == count) && !d_valid;

  // Copy pass source selection.
  idx_x_t cp_o_x, cp_src;
  logic   cp_pre, cp_ins, cp_issue, copy_end;

  assign cp_o_x   = {1'b0, cp_o};
  assign cp_pre   = (cp_o < ed_a);
  assign cp_ins   = (cp_o_x < ({1'b0, ed_a} + XW'(ed_k)));
  assign cp_src   = cp_o_x + {1'b0, ed_b} - {1'b0, ed_a} - XW'(ed_k);
  assign cp_issue = (state == rlrm_pkg::S_COPY) && (cp_o < new_count);
  assign copy_end = (state == rlrm_pkg::S_COPY) && (cp_o == new_count) && !w_valid;

  // Final decision for every command.
  logic              c_apply, c_term;
  rlrm_pkg::status_t c_status;
  rlrm_pkg::len_t    c_rs, c_re;
  idx_t              c_a, c_b;
  logic [1:0]        c_k, c_need;
  rlrm_pkg::run_t    c_e0, c_e1, c_e2;
  logic              head_ex, tail_ex, lft_ex, rgt_ex, merge, lm, rm;
  rlrm_pkg::run_t    lft, rgt, head_run, tail_run, mid_run;
  rlrm_pkg::len_t    lm_len, rm_len;
  logic              full;

  always_comb begin
    c_apply  = 1'b0;
    c_term   = 1'b0;
    c_status = rlrm_pkg::STAT_OK;
    c_rs     = '0;
    c_re     = '0;
    c_a      = a_idx;
    c_b      = a_idx;
    c_k      = 2'd0;
    c_need   = 2'd0;
    full     = 1'b0;
    c_e0     = '0;
    c_e1     = '0;
    c_e2     = '0;
    head_ex  = (a_off != '0);
    tail_ex  = (b_tail != '0);
    head_run = '{flag: a_cur.flag, len: a_off};
    tail_run = '{flag: b_cur.flag, len: b_tail};
    lft_ex   = head_ex || a_has_prev;
    lft      = head_ex ? head_run : a_prev;
    rgt_ex   = tail_ex || b_has_n1;
    rgt      = tail_ex ? tail_run : b_n1;
    merge    = lft_ex && rgt_ex && (lft.flag == rgt.flag);
    lm       = (mk_off == '0) && mk_prev_ex && mk_prev.flag;
    rm       = (mk_rest == mk_n) && mk_next_ex && mk_next.flag;
    lm_len   = lm ? mk_prev.len : '0;
    rm_len   = rm ? mk_next.len : '0;
    mid_run  = '{flag: 1'b1, len: mk_n + lm_len + rm_len};
    unique case (cmd)
      rlrm_pkg::CMD_CUT: begin
        if (endp <= pos) begin
          c_status = rlrm_pkg::STAT_ZERO;
        end else if ({1'b0, endp} > sum) begin
          c_status = rlrm_pkg::STAT_PAST;
        end else begin
          c_apply = 1'b1;
          c_a     = a_idx - IW'(merge && !head_ex);
          c_b     = b_idx + IW'(1) + IW'(merge && !tail_ex);
          if (merge) begin
            c_k  = 2'd1;
            c_e0 = '{flag: lft.flag, len: lft.len + rgt.len};
          end else if (head_ex && tail_ex) begin
            c_k  = 2'd2;
            c_e0 = head_run;
            c_e1 = tail_run;
          end else if (head_ex) begin
            c_k  = 2'd1;
            c_e0 = head_run;
          end else if (tail_ex) begin
            c_k  = 2'd1;
            c_e0 = tail_run;
          end
        end
      end
      rlrm_pkg::CMD_GROW: begin
        // Pick the edit first, then check the error cases in order.
        if (!a_has_cur) begin
          if (a_has_prev && !a_prev.flag) begin
            c_a  = a_idx - IW'(1);
            c_b  = a_idx;
            c_k  = 2'd1;
            c_e0 = '{flag: 1'b0, len: a_prev.len + len};
          end else begin
            c_need = 2'd1;
            c_k    = 2'd1;
            c_e0   = '{flag: 1'b0, len: len};
          end
        end else if (!a_cur.flag) begin
          c_b  = a_idx + IW'(1);
          c_k  = 2'd1;
          c_e0 = '{flag: 1'b0, len: a_cur.len + len};
        end else if (!head_ex && a_has_prev && !a_prev.flag) begin
          c_a  = a_idx - IW'(1);
          c_k  = 2'd1;
          c_e0 = '{flag: 1'b0, len: a_prev.len + len};
        end else if (!head_ex) begin
          c_need = 2'd1;
          c_k    = 2'd1;
          c_e0   = '{flag: 1'b0, len: len};
        end else begin
          c_need = 2'd2;
          c_b    = a_idx + IW'(1);
          c_k    = 2'd3;
          c_e0   = '{flag: 1'b1, len: a_off};
          c_e1   = '{flag: 1'b0, len: len};
          c_e2   = '{flag: 1'b1, len: a_rest};
        end
        full = ((count_x + XW'(c_need)) > XW'(MAX_RUNS));
        if (len == '0) begin
          c_status = rlrm_pkg::STAT_ZERO;
        end else if ({1'b0, pos} > sum) begin
          c_status = rlrm_pkg::STAT_PAST;
        end else if (tot_n[LB] || full) begin
          c_status = rlrm_pkg::STAT_FULL;
        end else begin
          c_apply = 1'b1;
        end
      end
      rlrm_pkg::CMD_QUERY: begin
        if ({1'b0, pos} > sum) begin
          c_status = rlrm_pkg::STAT_PAST;
        end else begin
          c_term = a_has_cur ? a_cur.flag : (a_has_prev && a_prev.flag);
        end
      end
      default: begin
        c_need = 2'((mk_off != '0)) + 2'((mk_rest != mk_n));
        full   = ((count_x + XW'(c_need)) > XW'(MAX_RUNS));
        c_a    = mk_idx - IW'(lm);
        c_b    = mk_idx + IW'(1) + IW'(rm);
        if (mk_off != '0) begin
          c_e0 = '{flag: 1'b0, len: mk_off};
          c_e1 = mid_run;
          c_e2 = '{flag: 1'b0, len: mk_rest - mk_n};
          c_k  = (mk_rest != mk_n) ? 2'd3 : 2'd2;
        end else begin
          c_e0 = mid_run;
          c_e1 = '{flag: 1'b0, len: mk_rest - mk_n};
          c_k  = (mk_rest != mk_n) ? 2'd2 : 2'd1;
        end
        if (len == '0) begin
          c_status = rlrm_pkg::STAT_ZERO;
        end else if ({1'b0, pos} >= sum) begin
          c_status = rlrm_pkg::STAT_PAST;
        end else if (mk_early) begin
          c_rs = pos;
          c_re = pos;
        end else if (mk_incons) begin
          c_status = rlrm_pkg::STAT_INCONS;
        end else if (full) begin
          c_status = rlrm_pkg::STAT_FULL;
        end else begin
          c_apply = 1'b1;
          c_rs    = mk_cur;
          c_re    = mk_cur + mk_n;
        end
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rlrm_pkg::S_IDLE:  if (start) state_next = rlrm_pkg::S_SCAN;
      rlrm_pkg::S_SCAN:  if (scan_end) state_next = rlrm_pkg::S_CALC1;
      rlrm_pkg::S_CALC1: state_next = rlrm_pkg::S_CALC2;
      rlrm_pkg::S_CALC2: state_next = rlrm_pkg::S_CALC3;
      rlrm_pkg::S_CALC3: state_next = c_apply ? rlrm_pkg::S_COPY : rlrm_pkg::S_DONE;
      rlrm_pkg::S_COPY:  if (copy_end) state_next = rlrm_pkg::S_DONE;
      rlrm_pkg::S_DONE:  state_next = rlrm_pkg::S_IDLE;
      default:           state_next = rlrm_pkg::S_IDLE;
    endcase
  end

  // Outputs and memory port.
  always_comb begin
    busy        = (state != rlrm_pkg::S_IDLE);
    done        = (state == rlrm_pkg::S_DONE);
    in_terminal = res_term;
    range_start = res_rs;
    range_end   = res_re;
    status      = res_status;
    mem_raddr   = rd_cnt[AW-1:0];
    if (state == rlrm_pkg::S_COPY) begin
      mem_raddr = cp_pre ? cp_o[AW-1:0] : cp_src[AW-1:0];
    end
    mem_we    = w_valid;
    mem_waddr = w_idx[AW-1:0];
    if (w_ram) begin
      mem_wdata = mem_rdata;
    end else begin
      unique case (w_ent)
        2'd0:    mem_wdata = ed_e0;
        2'd1:    mem_wdata = ed_e1;
        default: mem_wdata = ed_e2;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rlrm_pkg::S_IDLE;
      count   <= '0;
      bank    <= 1'b0;
      d_valid <= 1'b0;
      w_valid <= 1'b0;
    end else begin
      state   <= state_next;
      d_valid <= (state == rlrm_pkg::S_SCAN) && (rd_cnt < count);
      w_valid <= cp_issue;
      if (copy_end) begin
        bank  <= !bank;
        count <= new_count;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    // Request latch and scan setup.
    if (state == rlrm_pkg::S_IDLE && start) begin
      cmd     <= rlrm_pkg::cmd_t'(command);
      pos     <= position;
      endp    <= end_pos;
      len     <= length;
      rd_cnt  <= '0;
      sum     <= '0;
      a_found <= 1'b0;
      b_found <= 1'b0;
    end

    // Scan: walk every run once, locating the start and end positions.
    if (state == rlrm_pkg::S_SCAN) begin
      if (rd_cnt < count) begin
        rd_cnt <= rd_cnt + IW'(1);
      end
      d_idx <= rd_cnt;
      if (d_valid) begin
        sum  <= d_sum;
        last <= mem_rdata;
        if (a_hit) begin
          a_found <= 1'b1;
          a_idx   <= d_idx;
          a_start <= sum;
          a_end   <= d_sum;
          a_cur   <= mem_rdata;
          a_prev  <= last;
        end else if (a_found) begin
          if ({1'b0, d_idx} == (a_idx_x + XW'(1))) a_n1 <= mem_rdata;
          if ({1'b0, d_idx} == (a_idx_x + XW'(2))) a_n2 <= mem_rdata;
        end
        if (b_hit) begin
          b_found <= 1'b1;
          b_idx   <= d_idx;
          b_end   <= d_sum;
          b_cur   <= mem_rdata;
        end else if (b_found) begin
          if ({1'b0, d_idx} == (b_idx_x + XW'(1))) b_n1 <= mem_rdata;
        end
      end
      if (scan_end && !a_found) begin
        a_idx   <= count;
        a_start <= sum;
        a_end   <= sum;
        a_prev  <= last;
      end
    end

    // Distances inside the located runs.
    if (state == rlrm_pkg::S_CALC1) begin
      a_off  <= pos - a_start[LB-1:0];
      a_rest <= a_end[LB-1:0] - pos;
      b_tail <= b_end[LB-1:0] - endp;
      tot_n  <= sum + {1'b0, len};
    end

    // Mark: find the non-resident run to work on and the byte count.
    if (state == rlrm_pkg::S_CALC2) begin
      if (a_cur.flag) begin
        mk_early   <= (len <= a_rest);
        mk_incons  <= !a_has_n1 || a_n1.flag;
        mk_idx     <= a_idx + IW'(1);
        mk_cur     <= a_end[LB-1:0];
        mk_off     <= '0;
        mk_rest    <= a_n1.len;
        mk_n       <= (a_n1.len < (len - a_rest)) ? a_n1.len : (len - a_rest);
        mk_prev    <= a_cur;
        mk_prev_ex <= 1'b1;
        mk_next    <= a_n2;
        mk_next_ex <= a_has_n2;
      end else begin
        mk_early   <= 1'b0;
        mk_incons  <= 1'b0;
        mk_idx     <= a_idx;
        mk_cur     <= pos;
        mk_off     <= a_off;
        mk_rest    <= a_rest;
        mk_n       <= (a_rest < len) ? a_rest : len;
        mk_prev    <= a_prev;
        mk_prev_ex <= a_has_prev;
        mk_next    <= a_n1;
        mk_next_ex <= a_has_n1;
      end
    end

    // Register the result and the edit.
    if (state == rlrm_pkg::S_CALC3) begin
      res_term   <= c_term;
      res_rs     <= c_rs;
      res_re     <= c_re;
      res_status <= c_status;
      ed_a       <= c_a;
      ed_b       <= c_b;
      ed_k       <= c_k;
      ed_e0      <= c_e0;
      ed_e1      <= c_e1;
      ed_e2      <= c_e2;
      new_count  <= IW'(count_x + XW'(c_k) - ({1'b0, c_b} - {1'b0, c_a}));
      cp_o       <= '0;
    end

    // Copy: rebuild the list into the other bank, one run a cycle.
    if (cp_issue) begin
      cp_o  <= cp_o + IW'(1);
      w_idx <= cp_o;
      w_ram <= cp_pre || !cp_ins;
      w_ent <= 2'(cp_o - ed_a);
    end
  end

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_x <= XW'(MAX_RUNS))
    else $error("run count exceeds the store depth");

  a_write_in_copy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == rlrm_pkg::S_COPY))
    else $error("memory write outside the copy pass");

  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == rlrm_pkg::S_SCAN))
    else $error("accepted request did not start a scan");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block stayed busy after its result");

endmodule

// ----- design/run_length_residency_map_unit.sv -----
`timescale 1ns / 1ps

// Run-length residency map. A request is taken when start is high and busy is
// low; exactly one result follows, shown for a single cycle with done high,
// and the receiver must take it then because it cannot stall the block. The
// runs live in two banks of single-read-port memory that swap roles on every
// change. Each request first reads every run once, then decides through the
// CALC1, CALC2 and CALC3 states, and when the list changes copies the new
// list into the other bank, then shows the result for one cycle. Busy stays
// high from the request through the result, and the next request can be
// taken in the cycle after the result. The one memory read port, used once
// per run in each pass, sets how long a request takes.
module run_length_residency_map_unit #(
  parameter int MAX_RUNS = rlrm_pkg::DEFAULT_MAX_RUNS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      command,
  input  logic [rlrm_pkg::LEN_BITS-1:0]   position,
  input  logic [rlrm_pkg::LEN_BITS-1:0]   end_pos,
  input  logic [rlrm_pkg::LEN_BITS-1:0]   length,
  output logic                            done,
  output logic                            in_terminal,
  output logic [rlrm_pkg::LEN_BITS-1:0]   range_start,
  output logic [rlrm_pkg::LEN_BITS-1:0]   range_end,
  output logic [2:0]                      status
);

  localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

  logic [AW-1:0]     raddr, waddr;
  logic              we, bank;
  rlrm_pkg::run_t    wdata, rdata;
  logic [rlrm_pkg::RUN_BITS-1:0] rdata0, rdata1;
  rlrm_pkg::status_t status_i;

  // Reads come from the active bank, writes go to the other one.
  assign rdata  = bank ? rlrm_pkg::run_t'(rdata1) : rlrm_pkg::run_t'(rdata0);
  assign status = status_i;

  rlrm_ram #(
    .WIDTH (rlrm_pkg::RUN_BITS),
    .DEPTH (MAX_RUNS)
  ) u_bank0 (
    .clk   (clk),
    .we    (we && bank),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata0)
  );

  rlrm_ram #(
    .WIDTH (rlrm_pkg::RUN_BITS),
    .DEPTH (MAX_RUNS)
  ) u_bank1 (
    .clk   (clk),
    .we    (we && !bank),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata1)
  );

  rlrm_ctrl #(
    .MAX_RUNS (MAX_RUNS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .position    (position),
    .end_pos     (end_pos),
    .length      (length),
    .done        (done),
    .in_terminal (in_terminal),
    .range_start (range_start),
    .range_end   (range_end),
    .status      (status_i),
    .mem_raddr   (raddr),
    .mem_rdata   (rdata),
    .mem_we      (we),
    .mem_waddr   (waddr),
    .mem_wdata   (wdata),
    .bank        (bank)
  );

endmodule
